// ----- rtl/process_fifo_with_pid_removal_macros.svh -----
// ----------------------------------------------------------------------------
// Process queue assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PROCESS_FIFO_WITH_PID_REMOVAL_MACROS_SVH
`define PROCESS_FIFO_WITH_PID_REMOVAL_MACROS_SVH

// same-cycle implication
`define PFQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("process queue assertion failed");

// next-cycle implication
`define PFQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("process queue assertion failed");

`endif

// ----- rtl/pfq_pkg.sv -----
// ----------------------------------------------------------------------------
// Process queue package
// Field widths, operation codes and the structs shared by the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfq_pkg;

   localparam int FUNC_W    = 2;
   localparam int PID_W     = 22;
   localparam int PRI_W     = 8;
   localparam int RT_W      = 16;
   localparam int COUNT_W   = 5;
   localparam int DEPTH_DEF = 16;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   typedef struct packed {
      logic [RT_W-1:0]  rt;
      logic [PRI_W-1:0] pri;
      logic [PID_W-1:0] pid;
   } entry_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      entry_type         ent;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] count;
      entry_type          ent;
   } res_type;

endpackage

`default_nettype wire

// ----- rtl/pfq_mem.sv -----
// ----------------------------------------------------------------------------
// Process queue entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfq_mem #(
   parameter int  DEPTH = pfq_pkg::DEPTH_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire pfq_pkg::entry_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output pfq_pkg::entry_type     rd_data
);

   pfq_pkg::entry_type mem_ff [DEPTH];
   pfq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/pfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Process queue controller
// Push at tail, scan for the head or a pid, then shift later entries down.
// ----------------------------------------------------------------------------
`default_nettype none

`include "process_fifo_with_pid_removal_macros.svh"

module pfq_ctrl #(
   parameter int  DEPTH = pfq_pkg::DEPTH_DEF,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pfq_pkg::req_type   req,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output pfq_pkg::res_type        res,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output pfq_pkg::entry_type      wr_data,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  wire pfq_pkg::entry_type rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic                      pend_ff, pend_in;
   logic [AW-1:0]             pend_idx_ff, pend_idx_in;
   logic                      pop_ff, pop_in;
   logic [pfq_pkg::PID_W-1:0] key_ff, key_in;
   logic                      ok_ff, ok_in;
   pfq_pkg::entry_type        got_ff, got_in;

   logic                      issue;
   logic                      hit;
   logic [CW+pfq_pkg::COUNT_W-1:0] cnt_wide;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      pop_in      = pop_ff;
      key_in      = key_ff;
      ok_in       = ok_ff;
      got_in      = got_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = pend_idx_ff - 1'b1;
      wr_data     = rd_data;
      res_valid   = 1'b0;
      issue       = idx_ff < cnt_ff;
      hit         = pop_ff || (rd_data.pid == key_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ok_in    = 1'b0;
               got_in   = '0;
               key_in   = req.ent.pid;
               pop_in   = (req.func == pfq_pkg::FUNC_POP);
               idx_in   = '0;
               state_in = ST_DONE;
               case (req.func)
                  pfq_pkg::FUNC_PUSH: begin
                     if (cnt_ff < CW'(DEPTH)) begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[AW-1:0];
                        wr_data = req.ent;
                        cnt_in  = cnt_ff + 1'b1;
                        ok_in   = 1'b1;
                     end
                  end
                  pfq_pkg::FUNC_POP, pfq_pkg::FUNC_REMOVE: begin
                     if (cnt_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en       = issue;
            pend_in     = issue;
            pend_idx_in = idx_ff[AW-1:0];
            idx_in      = idx_ff + {{(CW-1){1'b0}}, issue};
            if (pend_ff && hit) begin
               ok_in    = 1'b1;
               got_in   = rd_data;
               state_in = ST_SHIFT;
            end else if (!issue) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            rd_en       = issue;
            pend_in     = issue;
            pend_idx_in = idx_ff[AW-1:0];
            idx_in      = idx_ff + {{(CW-1){1'b0}}, issue};
            wr_en       = pend_ff;
            if (!pend_ff && !issue) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      pop_ff      <= pop_in;
      key_ff      <= key_in;
      ok_ff       <= ok_in;
      got_ff      <= got_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign cnt_wide  = {{pfq_pkg::COUNT_W{1'b0}}, cnt_ff};
   assign res.ok    = ok_ff;
   assign res.ent   = got_ff;
   assign res.count = cnt_wide[pfq_pkg::COUNT_W-1:0];

   `PFQ_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_ff <= CW'(DEPTH))
   `PFQ_ASSERT_IMPL(a_port_apart, wr_en && rd_en, wr_addr != rd_addr)
   `PFQ_ASSERT_IMPL(a_shift_addr, (state_ff == ST_SHIFT) && wr_en, pend_idx_ff != '0)
   `PFQ_ASSERT_NEXT(a_remove_dec, (state_ff == ST_SHIFT) && (state_in == ST_DONE),
      cnt_ff == $past(cnt_ff) - 1'b1)
   `PFQ_ASSERT_IMPL(a_miss_zero, (state_ff == ST_DONE) && !ok_ff, got_ff == '0)

endmodule

`default_nettype wire

// ----- rtl/process_fifo_with_pid_removal.sv -----
// ----------------------------------------------------------------------------
// Process queue with removal by pid
// Ordered queue of process descriptors; push, pop and remove-by-pid.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one command word: tuser selects push, pop or remove
//   by pid; tdata carries pid, priority and runtime. rsp channel returns one
//   word per command: tuser is the success flag, tdata the removed entry
//   (zero when nothing is removed) and the entry count after the command.
//   Entries sit in one memory, slot 0 at the head. A push writes the tail
//   slot and completes without a scan. Pop and remove read from the head one
//   slot per cycle until a match, then move each later slot down one place;
//   a miss ends the scan with no shift, and an empty queue skips the scan.
//   One command is in work at a time; the next is accepted once the current
//   result has moved into the output register, even while that register
//   still waits on rsp_tready. A stalled receiver holds the result and, once
//   the next command completes, stalls the queue.
//   Reset empties the queue; slot contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module process_fifo_with_pid_removal #(
   parameter int DEPTH = pfq_pkg::DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // pid[21:0], priority_req[29:22], runtime[45:30], zero fill
   input  wire logic [pfq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func[1:0]
   input  wire logic [pfq_pkg::FUNC_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // out_pid[21:0], out_priority[29:22], out_runtime[45:30], count[50:46], zero fill
   output logic [pfq_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // ok[0]
   output logic                                 rsp_tuser
);

   localparam int AW     = $clog2(DEPTH);
   localparam int RSP_DW = pfq_pkg::PID_W + pfq_pkg::PRI_W + pfq_pkg::RT_W
                           + pfq_pkg::COUNT_W;

   pfq_pkg::req_type   req;
   pfq_pkg::res_type   res;
   logic               res_valid;
   logic               res_ready;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   pfq_pkg::entry_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   pfq_pkg::entry_type rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   pfq_pkg::res_type   rsp_ff;

   assign req.func    = req_tuser;
   assign req.ent.pid = req_tdata[pfq_pkg::PID_W-1:0];
   assign req.ent.pri = req_tdata[pfq_pkg::PID_W +: pfq_pkg::PRI_W];
   assign req.ent.rt  = req_tdata[pfq_pkg::PID_W + pfq_pkg::PRI_W +: pfq_pkg::RT_W];

   pfq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   pfq_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = {{(pfq_pkg::RSP_TDATA_W - RSP_DW){1'b0}}, rsp_ff.count,
                        rsp_ff.ent.rt, rsp_ff.ent.pri, rsp_ff.ent.pid};

endmodule

`default_nettype wire
